// ----- rtl/wav_riff_header_parser_defines.svh -----
// Assertion macros used by the file that checks the parser.
`ifndef WAV_RIFF_HEADER_PARSER_DEFINES_SVH
`define WAV_RIFF_HEADER_PARSER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define WRP_ASSERT_SAME(label, pre, post) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error("wav_riff_header_parser: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define WRP_ASSERT_NEXT(label, pre, post) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error("wav_riff_header_parser: next-cycle check failed");

`endif

// ----- rtl/wrp_pkg.sv -----
package wrp_pkg;

   localparam logic [31:0] TAG_RIFF = 32'h4646_4952;  // "RIFF" little endian
   localparam logic [31:0] TAG_WAVE = 32'h4556_4157;  // "WAVE"
   localparam logic [31:0] TAG_FMT  = 32'h2074_6d66;  // "fmt "
   localparam logic [31:0] TAG_DATA = 32'h6174_6164;  // "data"

   localparam logic [2:0] STATUS_OK       = 3'd0;
   localparam logic [2:0] STATUS_NOT_RIFF = 3'd1;
   localparam logic [2:0] STATUS_NOT_WAVE = 3'd2;
   localparam logic [2:0] STATUS_NO_FMT   = 3'd3;
   localparam logic [2:0] STATUS_NO_DATA  = 3'd4;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       end_of_buffer;
   } item_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [15:0] channels;
      logic [31:0] sample_rate;
      logic [15:0] bits_per_sample;
      logic [31:0] data_length;
      logic [31:0] data_offset;
   } rsp_type;

endpackage

// ----- rtl/wrp_in_stage.sv -----
module wrp_in_stage (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  wrp_pkg::item_type req_item,
   input  logic              advance,
   output logic              item_valid,
   output wrp_pkg::item_type item
);

   logic              valid_ff;
   logic              valid_in;
   wrp_pkg::item_type item_ff;
   logic              accept;

   // The held item leaves whenever the result side can advance.
   assign req_stall  = valid_ff && !advance;
   assign accept     = req_valid && !req_stall;
   assign valid_in   = accept ? 1'b1 : (advance ? 1'b0 : valid_ff);
   assign item_valid = valid_ff;
   assign item       = item_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (accept) begin
         item_ff <= req_item;
      end
   end

endmodule

// ----- rtl/wrp_parser.sv -----
module wrp_parser (
   input  logic              clock,
   input  logic              reset,
   input  logic              fire,
   input  wrp_pkg::item_type item,
   output logic              got,
   output wrp_pkg::rsp_type  res
);

   typedef enum logic [3:0] {
      PH_TAG_RIFF,
      PH_RIFF_SIZE,
      PH_TAG_WAVE,
      PH_FMT_ID,
      PH_FMT_HDR_SIZE,
      PH_FMT_SKIP_SIZE,
      PH_FMT_SKIP,
      PH_FMT_BODY,
      PH_DATA_ID,
      PH_DATA_HDR_SIZE,
      PH_DATA_SKIP_SIZE,
      PH_DATA_SKIP
   } phase_type;

   // Byte offsets inside the fmt body.
   localparam logic [4:0] OFS_CH_LO   = 5'd2;
   localparam logic [4:0] OFS_CH_HI   = 5'd3;
   localparam logic [4:0] OFS_RATE_0  = 5'd4;
   localparam logic [4:0] OFS_RATE_1  = 5'd5;
   localparam logic [4:0] OFS_RATE_2  = 5'd6;
   localparam logic [4:0] OFS_RATE_3  = 5'd7;
   localparam logic [4:0] OFS_BITS_LO = 5'd14;
   localparam logic [4:0] OFS_BITS_HI = 5'd15;
   localparam logic [4:0] FIELD_BYTES = 5'd4;
   localparam logic [4:0] BODY_BYTES  = 5'd16;

   phase_type   phase_ff, phase_in;
   logic [31:0] pos_ff, pos_in;
   logic [31:0] window_ff, window_in;
   logic [31:0] skip_ff, skip_in;
   logic [4:0]  count_ff, count_in;
   logic [15:0] ch_ff, ch_in;
   logic [31:0] rate_ff, rate_in;
   logic [15:0] bits_ff, bits_in;
   logic        reported_ff, reported_in;

   logic [4:0]  count_inc;
   logic        count_done;
   logic [31:0] window_shift;
   logic [7:0]  b;
   logic        eob;
   logic        clear_all;
   logic [2:0]  st;
   logic [31:0] len;
   logic [31:0] off;

   assign b            = item.data_byte;
   assign eob          = item.end_of_buffer;
   assign count_inc    = count_ff + 5'd1;
   assign count_done   = (count_inc >= FIELD_BYTES);
   assign window_shift = {b, window_ff[31:8]};

   always_comb begin
      phase_in    = phase_ff;
      pos_in      = pos_ff;
      window_in   = window_ff;
      skip_in     = skip_ff;
      count_in    = count_ff;
      ch_in       = ch_ff;
      rate_in     = rate_ff;
      bits_in     = bits_ff;
      reported_in = reported_ff;
      got         = 1'b0;
      clear_all   = 1'b0;
      st          = wrp_pkg::STATUS_OK;
      len         = '0;
      off         = '0;

      if (reported_ff) begin
         // Bytes after a result are dropped; the end mark rearms.
         clear_all = eob;
      end else begin
         case (phase_ff)
            PH_TAG_RIFF: begin
               window_in = window_shift;
               count_in  = count_done ? 5'd0 : count_inc;
               if (count_done) begin
                  if (window_shift != wrp_pkg::TAG_RIFF) begin
                     got = 1'b1;
                     st  = wrp_pkg::STATUS_NOT_RIFF;
                  end else begin
                     phase_in = PH_RIFF_SIZE;
                  end
               end
            end
            PH_RIFF_SIZE: begin
               count_in = count_done ? 5'd0 : count_inc;
               if (count_done) begin
                  phase_in = PH_TAG_WAVE;
               end
            end
            PH_TAG_WAVE: begin
               window_in = window_shift;
               count_in  = count_done ? 5'd0 : count_inc;
               if (count_done) begin
                  if (window_shift != wrp_pkg::TAG_WAVE) begin
                     got = 1'b1;
                     st  = wrp_pkg::STATUS_NOT_WAVE;
                  end else begin
                     phase_in = PH_FMT_ID;
                  end
               end
            end
            PH_FMT_ID: begin
               window_in = window_shift;
               count_in  = count_done ? 5'd0 : count_inc;
               if (count_done) begin
                  phase_in = (window_shift == wrp_pkg::TAG_FMT) ? PH_FMT_HDR_SIZE
                                                               : PH_FMT_SKIP_SIZE;
               end
            end
            PH_DATA_ID: begin
               window_in = window_shift;
               count_in  = count_done ? 5'd0 : count_inc;
               if (count_done) begin
                  phase_in = (window_shift == wrp_pkg::TAG_DATA) ? PH_DATA_HDR_SIZE
                                                                : PH_DATA_SKIP_SIZE;
               end
            end
            PH_FMT_HDR_SIZE: begin
               count_in = count_done ? 5'd0 : count_inc;
               if (count_done) begin
                  phase_in = PH_FMT_BODY;
               end
            end
            PH_FMT_SKIP_SIZE: begin
               window_in = window_shift;
               count_in  = count_done ? 5'd0 : count_inc;
               if (count_done) begin
                  skip_in  = window_shift;
                  phase_in = (window_shift != 32'd0) ? PH_FMT_SKIP : PH_FMT_ID;
               end
            end
            PH_DATA_SKIP_SIZE: begin
               window_in = window_shift;
               count_in  = count_done ? 5'd0 : count_inc;
               if (count_done) begin
                  skip_in  = window_shift;
                  phase_in = (window_shift != 32'd0) ? PH_DATA_SKIP : PH_DATA_ID;
               end
            end
            PH_FMT_SKIP: begin
               skip_in = skip_ff - 32'd1;
               if (skip_in == 32'd0) begin
                  phase_in = PH_FMT_ID;
               end
            end
            PH_DATA_SKIP: begin
               skip_in = skip_ff - 32'd1;
               if (skip_in == 32'd0) begin
                  phase_in = PH_DATA_ID;
               end
            end
            PH_FMT_BODY: begin
               case (count_ff)
                  OFS_CH_LO:   ch_in[7:0]     = b;
                  OFS_CH_HI:   ch_in[15:8]    = b;
                  OFS_RATE_0:  rate_in[7:0]   = b;
                  OFS_RATE_1:  rate_in[15:8]  = b;
                  OFS_RATE_2:  rate_in[23:16] = b;
                  OFS_RATE_3:  rate_in[31:24] = b;
                  OFS_BITS_LO: bits_in[7:0]   = b;
                  OFS_BITS_HI: bits_in[15:8]  = b;
                  default: ;
               endcase
               // The walk resumes after 16 body bytes whatever the size says.
               if (count_inc >= BODY_BYTES) begin
                  count_in = 5'd0;
                  phase_in = PH_DATA_ID;
               end else begin
                  count_in = count_inc;
               end
            end
            PH_DATA_HDR_SIZE: begin
               window_in = window_shift;
               count_in  = count_done ? 5'd0 : count_inc;
               if (count_done) begin
                  // With the end mark here no audio byte follows.
                  got = 1'b1;
                  st  = eob ? wrp_pkg::STATUS_NO_DATA : wrp_pkg::STATUS_OK;
                  len = window_shift;
                  off = pos_ff + 32'd1;
               end
            end
            default: begin
               phase_in = PH_TAG_RIFF;
               count_in = 5'd0;
            end
         endcase

         pos_in = pos_ff + 32'd1;

         // The end mark without a result reports where the walk stopped.
         if (!got && eob) begin
            got = 1'b1;
            case (phase_in)
               PH_TAG_RIFF: st = wrp_pkg::STATUS_NOT_RIFF;
               PH_RIFF_SIZE, PH_TAG_WAVE: st = wrp_pkg::STATUS_NOT_WAVE;
               PH_FMT_ID, PH_FMT_HDR_SIZE, PH_FMT_SKIP_SIZE, PH_FMT_SKIP:
                  st = wrp_pkg::STATUS_NO_FMT;
               PH_FMT_BODY:
                  st = (count_in == 5'd0) ? wrp_pkg::STATUS_NO_FMT
                                          : wrp_pkg::STATUS_NO_DATA;
               default: st = wrp_pkg::STATUS_NO_DATA;
            endcase
         end

         if (got) begin
            clear_all   = eob;
            reported_in = !eob;
         end
      end

      if (clear_all) begin
         phase_in    = PH_TAG_RIFF;
         pos_in      = '0;
         window_in   = '0;
         skip_in     = '0;
         count_in    = '0;
         ch_in       = '0;
         rate_in     = '0;
         bits_in     = '0;
         reported_in = 1'b0;
      end
   end

   // Result fields other than status are zero on any error.
   always_comb begin
      res.status = st;
      if (st == wrp_pkg::STATUS_OK) begin
         res.channels        = ch_in;
         res.sample_rate     = rate_ff;
         res.bits_per_sample = bits_ff;
         res.data_length     = len;
         res.data_offset     = off;
      end else begin
         res.channels        = '0;
         res.sample_rate     = '0;
         res.bits_per_sample = '0;
         res.data_length     = '0;
         res.data_offset     = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_TAG_RIFF;
         pos_ff      <= '0;
         window_ff   <= '0;
         skip_ff     <= '0;
         count_ff    <= '0;
         ch_ff       <= '0;
         rate_ff     <= '0;
         bits_ff     <= '0;
         reported_ff <= 1'b0;
      end else if (fire) begin
         phase_ff    <= phase_in;
         pos_ff      <= pos_in;
         window_ff   <= window_in;
         skip_ff     <= skip_in;
         count_ff    <= count_in;
         ch_ff       <= ch_in;
         rate_ff     <= rate_in;
         bits_ff     <= bits_in;
         reported_ff <= reported_in;
      end
   end

endmodule

// ----- rtl/wrp_out_stage.sv -----
module wrp_out_stage (
   input  logic             clock,
   input  logic             reset,
   input  logic             load,
   input  wrp_pkg::rsp_type res,
   input  logic             rsp_stall,
   output logic             rsp_valid,
   output wrp_pkg::rsp_type rsp,
   output logic             advance
);

   logic             valid_ff;
   logic             valid_in;
   wrp_pkg::rsp_type rsp_ff;

   // The register can take a new result when empty or being drained.
   assign advance   = !valid_ff || !rsp_stall;
   assign valid_in  = load ? 1'b1 : (rsp_stall ? valid_ff : 1'b0);
   assign rsp_valid = valid_ff;
   assign rsp       = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (load) begin
         rsp_ff <= res;
      end
   end

endmodule

// ----- rtl/wav_riff_header_parser.sv -----
// Parses a WAV buffer streamed one byte per item and returns at most one result per buffer:
// the status, the fmt fields and the length and position of the data chunk. One byte is
// accepted every cycle while the result register is free or being drained; the per-byte
// parser state update is the single step between the input register and the result
// register, which loads a result as the byte that completes it leaves the input register. After a
// result the remaining bytes of the buffer are taken and dropped, and the byte that
// carries end_of_buffer rearms the parser for the next buffer.
`include "wav_riff_header_parser_defines.svh"

module wav_riff_header_parser (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic        req_end_of_buffer,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_status,
   output logic [15:0] rsp_channels,
   output logic [31:0] rsp_sample_rate,
   output logic [15:0] rsp_bits_per_sample,
   output logic [31:0] rsp_data_length,
   output logic [31:0] rsp_data_offset
);

   wrp_pkg::item_type req_item;
   wrp_pkg::item_type item;
   wrp_pkg::rsp_type  res;
   wrp_pkg::rsp_type  rsp;
   logic              item_valid;
   logic              advance;
   logic              fire;
   logic              got;

   assign req_item.data_byte     = req_data_byte;
   assign req_item.end_of_buffer = req_end_of_buffer;
   assign fire                   = item_valid && advance;

   wrp_in_stage u_in (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_item   (req_item),
      .advance    (advance),
      .item_valid (item_valid),
      .item       (item)
   );

   wrp_parser u_parser (
      .clock (clock),
      .reset (reset),
      .fire  (fire),
      .item  (item),
      .got   (got),
      .res   (res)
   );

   wrp_out_stage u_out (
      .clock     (clock),
      .reset     (reset),
      .load      (fire && got),
      .res       (res),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .rsp       (rsp),
      .advance   (advance)
   );

   assign rsp_status          = rsp.status;
   assign rsp_channels        = rsp.channels;
   assign rsp_sample_rate     = rsp.sample_rate;
   assign rsp_bits_per_sample = rsp.bits_per_sample;
   assign rsp_data_length     = rsp.data_length;
   assign rsp_data_offset     = rsp.data_offset;

   `WRP_ASSERT_NEXT(a_result_lands, fire && got, rsp_valid)
   `WRP_ASSERT_SAME(a_stall_cause, req_stall, item_valid && rsp_valid && rsp_stall)
   `WRP_ASSERT_SAME(a_error_zero, rsp_valid && (rsp_status != wrp_pkg::STATUS_OK),
      (rsp_channels == 16'd0) && (rsp_sample_rate == 32'd0) &&
      (rsp_bits_per_sample == 16'd0) && (rsp_data_length == 32'd0) &&
      (rsp_data_offset == 32'd0))

endmodule

// ----- sim/tb.sv -----
`timescale 1ns / 1ps

module tb;

   localparam int ITEMS_PER_PHASE = 340;
   localparam int HOLD_CYCLES     = 200;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_data_byte = 8'h00;
   logic        req_end_of_buffer = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [2:0]  rsp_status;
   logic [15:0] rsp_channels;
   logic [31:0] rsp_sample_rate;
   logic [15:0] rsp_bits_per_sample;
   logic [31:0] rsp_data_length;
   logic [31:0] rsp_data_offset;

   wav_riff_header_parser dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data_byte(req_data_byte),
      .req_end_of_buffer(req_end_of_buffer),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_status(rsp_status),
      .rsp_channels(rsp_channels),
      .rsp_sample_rate(rsp_sample_rate),
      .rsp_bits_per_sample(rsp_bits_per_sample),
      .rsp_data_length(rsp_data_length),
      .rsp_data_offset(rsp_data_offset)
   );

   // Tracks the parse of the byte stream and holds the header results still owed by the block.
   class wav_header_scoreboard;
      typedef enum logic [3:0] {
         PH_RIFF_TAG, PH_RIFF_SIZE, PH_WAVE_TAG, PH_FMT_ID, PH_FMT_LEN, PH_FMT_SKIP_LEN,
         PH_FMT_SKIP, PH_FMT_BODY, PH_DATA_ID, PH_DATA_LEN, PH_DATA_SKIP_LEN, PH_DATA_SKIP
      } phase_type;

      phase_type        phase;
      bit [31:0]        position;
      bit [31:0]        window;
      bit [31:0]        skip_left;
      bit [4:0]         count;
      bit [15:0]        chans;
      bit [31:0]        rate;
      bit [15:0]        bits;
      bit               finished;
      wrp_pkg::rsp_type expected_headers[$];
      int               mismatches;
      int               predicted;
      int               checked;
      int               status_tally[5];

      function new();
         rearm();
      endfunction

      function void rearm();
         phase = PH_RIFF_TAG;
         position = 0;
         window = 0;
         skip_left = 0;
         count = 0;
         chans = 0;
         rate = 0;
         bits = 0;
         finished = 0;
      endfunction

      function bit take_four();
         count = count + 1;
         if (count >= 4) begin
            count = 0;
            return 1'b1;
         end
         return 1'b0;
      endfunction

      function logic [2:0] status_at_end();
         case (phase)
            PH_RIFF_TAG: return wrp_pkg::STATUS_NOT_RIFF;
            PH_RIFF_SIZE, PH_WAVE_TAG: return wrp_pkg::STATUS_NOT_WAVE;
            PH_FMT_ID, PH_FMT_LEN, PH_FMT_SKIP_LEN, PH_FMT_SKIP:
               return wrp_pkg::STATUS_NO_FMT;
            // The fmt body has not started until its first byte is in.
            PH_FMT_BODY:
               return (count == 0) ? wrp_pkg::STATUS_NO_FMT : wrp_pkg::STATUS_NO_DATA;
            default: return wrp_pkg::STATUS_NO_DATA;
         endcase
      endfunction

      function void note_byte(bit [7:0] b, bit eob);
         bit               got;
         logic [2:0]       st;
         bit [31:0]        len;
         bit [31:0]        off;
         wrp_pkg::rsp_type r;
         got = 1'b0;
         st = wrp_pkg::STATUS_OK;
         len = 0;
         off = 0;
         if (finished) begin
            if (eob) rearm();
            return;
         end
         case (phase)
            PH_RIFF_TAG: begin
               window = {b, window[31:8]};
               if (take_four()) begin
                  if (window != wrp_pkg::TAG_RIFF) begin
                     got = 1'b1;
                     st = wrp_pkg::STATUS_NOT_RIFF;
                  end else
                     phase = PH_RIFF_SIZE;
               end
            end
            PH_RIFF_SIZE: if (take_four()) phase = PH_WAVE_TAG;
            PH_WAVE_TAG: begin
               window = {b, window[31:8]};
               if (take_four()) begin
                  if (window != wrp_pkg::TAG_WAVE) begin
                     got = 1'b1;
                     st = wrp_pkg::STATUS_NOT_WAVE;
                  end else
                     phase = PH_FMT_ID;
               end
            end
            PH_FMT_ID, PH_DATA_ID: begin
               window = {b, window[31:8]};
               if (take_four()) begin
                  if (phase == PH_FMT_ID)
                     phase = (window == wrp_pkg::TAG_FMT) ? PH_FMT_LEN : PH_FMT_SKIP_LEN;
                  else
                     phase = (window == wrp_pkg::TAG_DATA) ? PH_DATA_LEN : PH_DATA_SKIP_LEN;
               end
            end
            PH_FMT_LEN: if (take_four()) phase = PH_FMT_BODY;
            PH_FMT_SKIP_LEN, PH_DATA_SKIP_LEN: begin
               window = {b, window[31:8]};
               if (take_four()) begin
                  skip_left = window;
                  if (phase == PH_FMT_SKIP_LEN)
                     phase = (window != 0) ? PH_FMT_SKIP : PH_FMT_ID;
                  else
                     phase = (window != 0) ? PH_DATA_SKIP : PH_DATA_ID;
               end
            end
            PH_FMT_SKIP, PH_DATA_SKIP: begin
               skip_left = skip_left - 1;
               if (skip_left == 0) phase = (phase == PH_FMT_SKIP) ? PH_FMT_ID : PH_DATA_ID;
            end
            PH_FMT_BODY: begin
               case (count)
                  5'd2: chans[7:0] = b;
                  5'd3: chans[15:8] = b;
                  5'd4: rate[7:0] = b;
                  5'd5: rate[15:8] = b;
                  5'd6: rate[23:16] = b;
                  5'd7: rate[31:24] = b;
                  5'd14: bits[7:0] = b;
                  5'd15: bits[15:8] = b;
                  default: ;
               endcase
               // The walk resumes after 16 body bytes whatever the fmt size says.
               count = count + 1;
               if (count >= 16) begin
                  count = 0;
                  phase = PH_DATA_ID;
               end
            end
            PH_DATA_LEN: begin
               window = {b, window[31:8]};
               if (take_four()) begin
                  got = 1'b1;
                  st = eob ? wrp_pkg::STATUS_NO_DATA : wrp_pkg::STATUS_OK;
                  len = window;
                  off = position + 1;
               end
            end
            default: ;
         endcase
         position = position + 1;
         if (!got && eob) begin
            got = 1'b1;
            st = status_at_end();
         end
         if (got) begin
            r = '0;
            r.status = st;
            if (st == wrp_pkg::STATUS_OK) begin
               r.channels = chans;
               r.sample_rate = rate;
               r.bits_per_sample = bits;
               r.data_length = len;
               r.data_offset = off;
            end
            expected_headers.push_back(r);
            predicted++;
            status_tally[st]++;
            if (eob) rearm();
            else finished = 1'b1;
         end
      endfunction

      task report(string msg);
         mismatches++;
         if (mismatches <= 40) $display("[%0t] mismatch: %s", $time, msg);
      endtask

      task compare_field(string name, logic [31:0] seen, logic [31:0] want);
         if (seen !== want)
            report($sformatf("result %0d %s is 0x%0h, expected 0x%0h", checked, name, seen, want));
      endtask

      task check(wrp_pkg::rsp_type seen);
         wrp_pkg::rsp_type want;
         checked++;
         if (expected_headers.size() == 0) begin
            report($sformatf("result %0d (status %0d) arrived with none expected",
                             checked, seen.status));
            return;
         end
         want = expected_headers.pop_front();
         compare_field("status", 32'(seen.status), 32'(want.status));
         compare_field("channels", 32'(seen.channels), 32'(want.channels));
         compare_field("sample_rate", seen.sample_rate, want.sample_rate);
         compare_field("bits_per_sample", 32'(seen.bits_per_sample), 32'(want.bits_per_sample));
         compare_field("data_length", seen.data_length, want.data_length);
         compare_field("data_offset", seen.data_offset, want.data_offset);
      endtask
   endclass

   wav_header_scoreboard sb = new();

   bit [7:0] wav_bytes[$];
   int       sender_idle_pct = 0;
   int       receiver_idle_pct = 0;
   int       items_sent = 0;
   int       buffers_sent = 0;
   logic     holding_off = 1'b0;
   event     hold_request;

   initial begin
      forever begin
         #6 clock = ~clock;
      end
   end

   always @(posedge clock) begin
      rsp_stall <= holding_off || ($urandom_range(99) < receiver_idle_pct);
   end

   // A long receiver hold-off, counted here so the sender keeps offering items meanwhile.
   initial begin
      forever begin
         @(hold_request);
         holding_off <= 1'b1;
         repeat (HOLD_CYCLES) @(posedge clock);
         holding_off <= 1'b0;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         sb.check({rsp_status, rsp_channels, rsp_sample_rate, rsp_bits_per_sample,
                   rsp_data_length, rsp_data_offset});
   end

   function automatic void add_word(bit [31:0] w);
      for (int i = 0; i < 4; i++) wav_bytes.push_back(w[8*i +: 8]);
   endfunction

   // A chunk to be walked over; now and then its size runs far past the buffer.
   function automatic void add_chunk(bit data_search);
      bit [31:0] size;
      int        body;
      if ($urandom_range(3) == 0) add_word(data_search ? wrp_pkg::TAG_FMT : wrp_pkg::TAG_DATA);
      else add_word($urandom);
      if ($urandom_range(19) == 0) begin
         size = 32'hFFFF_FFF0 | 32'($urandom_range(15));
         body = 3;
      end else begin
         size = $urandom_range(0, 6);
         body = size;
      end
      add_word(size);
      repeat (body) wav_bytes.push_back(8'($urandom));
   endfunction

   function automatic void make_wave(int chunks_before_fmt, int chunks_before_data,
                                     int audio_len);
      wav_bytes.delete();
      add_word(wrp_pkg::TAG_RIFF);
      add_word($urandom);
      add_word(wrp_pkg::TAG_WAVE);
      repeat (chunks_before_fmt) add_chunk(1'b0);
      add_word(wrp_pkg::TAG_FMT);
      add_word(($urandom_range(1) == 1) ? 32'd16 : 32'($urandom));
      repeat (16) wav_bytes.push_back(8'($urandom));
      repeat (chunks_before_data) add_chunk(1'b1);
      add_word(wrp_pkg::TAG_DATA);
      add_word($urandom);
      repeat (audio_len) wav_bytes.push_back(8'($urandom));
   endfunction

   function automatic void cut_buffer(int keep);
      while (wav_bytes.size() > keep) void'(wav_bytes.pop_back());
   endfunction

   // Mostly well-formed files, some cut short or with a damaged RIFF header byte, the rest noise.
   function automatic void random_buffer();
      int pick;
      pick = $urandom_range(99);
      if (pick < 80) begin
         make_wave($urandom_range(0, 2), $urandom_range(0, 2), $urandom_range(0, 4));
         if (pick >= 65)
            cut_buffer($urandom_range(1, wav_bytes.size()));
         else if (pick >= 58)
            wav_bytes[$urandom_range(0, 11)] ^= 8'($urandom_range(1, 255));
      end else begin
         wav_bytes.delete();
         repeat ($urandom_range(1, 12)) wav_bytes.push_back(8'($urandom));
      end
   endfunction

   task automatic send_byte(input bit [7:0] value, input bit last);
      if (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data_byte <= value;
      req_end_of_buffer <= last;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sb.note_byte(value, last);
      items_sent++;
   endtask

   task automatic send_buffer();
      for (int i = 0; i < wav_bytes.size(); i++) send_byte(wav_bytes[i], i == wav_bytes.size() - 1);
      buffers_sent++;
   endtask

   task automatic run_phase(input int send_pct, input int recv_pct);
      int first_item;
      sender_idle_pct = send_pct;
      receiver_idle_pct = recv_pct;
      first_item = items_sent;
      while (items_sent - first_item < ITEMS_PER_PHASE) begin
         random_buffer();
         send_buffer();
      end
   endtask

   initial begin
      int cuts[6];
      cuts = '{2, 6, 12, 20, 25, 44};
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      sender_idle_pct = 15;
      receiver_idle_pct = 66;

      // Full files with every fmt field and the data length at their extremes, then one with chunks to skip.
      make_wave(0, 0, 2);
      for (int i = 20; i < 36; i++) wav_bytes[i] = 8'hFF;
      for (int i = 40; i < 44; i++) wav_bytes[i] = 8'hFF;
      send_buffer();
      make_wave(0, 0, 1);
      for (int i = 20; i < 44; i++) if (i < 36 || i >= 40) wav_bytes[i] = 8'h00;
      send_buffer();
      make_wave(2, 2, 3);
      send_buffer();

      // Ends inside the RIFF tag, the RIFF size, on the WAVE tag, on the fmt header,
      // inside the fmt body and on the byte that completes the data header.
      foreach (cuts[k]) begin
         make_wave(0, 0, 2);
         cut_buffer(cuts[k]);
         send_buffer();
      end

      wav_bytes.delete();
      wav_bytes.push_back(8'h00);
      send_buffer();

      wav_bytes.delete();
      add_word(wrp_pkg::TAG_RIFF ^ 32'h0100_0000);
      add_word($urandom);
      send_buffer();
      wav_bytes.delete();
      add_word(wrp_pkg::TAG_RIFF);
      add_word($urandom);
      add_word(wrp_pkg::TAG_WAVE ^ 32'h0000_0001);
      wav_bytes.push_back(8'($urandom));
      send_buffer();

      // Chunk sizes far beyond the buffer, in the fmt search and in the data search.
      wav_bytes.delete();
      add_word(wrp_pkg::TAG_RIFF);
      add_word($urandom);
      add_word(wrp_pkg::TAG_WAVE);
      add_word(32'h5453_494C);
      add_word(32'hFFFF_FFFF);
      repeat (3) wav_bytes.push_back(8'($urandom));
      send_buffer();
      make_wave(0, 0, 0);
      cut_buffer(36);
      add_word(32'h5453_494C);
      add_word(32'hFFFF_FFFF);
      repeat (2) wav_bytes.push_back(8'($urandom));
      send_buffer();

      run_phase(15, 66);

      // Short rejected buffers while the receiver holds off, so the block backs up.
      sender_idle_pct = 0;
      receiver_idle_pct = 0;
      -> hold_request;
      repeat (30) begin
         wav_bytes.delete();
         add_word(wrp_pkg::TAG_RIFF ^ 32'($urandom_range(1, 255)));
         repeat (2) wav_bytes.push_back(8'($urandom));
         send_buffer();
      end

      run_phase(66, 15);
      run_phase(0, 0);

      req_valid <= 1'b0;
      while (sb.expected_headers.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);

      $display("Sent %0d bytes in %0d buffers under three idle mixes and one long hold-off.",
               items_sent, buffers_sent);
      $display("Checked %0d results: %0d ok, %0d not RIFF, %0d not WAVE, %0d no fmt, %0d no data.",
               sb.checked, sb.status_tally[wrp_pkg::STATUS_OK],
               sb.status_tally[wrp_pkg::STATUS_NOT_RIFF],
               sb.status_tally[wrp_pkg::STATUS_NOT_WAVE],
               sb.status_tally[wrp_pkg::STATUS_NO_FMT],
               sb.status_tally[wrp_pkg::STATUS_NO_DATA]);
      if (sb.mismatches == 0) begin
         $display("** wav_riff_header_parser: PASSED **");
      end else begin
         $display("** wav_riff_header_parser: FAILED **");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("Timed out with %0d results still expected.", sb.expected_headers.size());
      $display("** wav_riff_header_parser: FAILED **");
      $finish;
   end

endmodule
